>>> hdl/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

	localparam logic [2:0] FN_SPHERE   = 3'd0;
	localparam logic [2:0] FN_BOX      = 3'd1;
	localparam logic [2:0] FN_TORUS    = 3'd2;
	localparam logic [2:0] FN_CAPSULE  = 3'd3;
	localparam logic [2:0] FN_CYLINDER = 3'd4;
	localparam logic [2:0] FN_PLANE    = 3'd5;

	localparam int FRAC_BITS = 16;

endpackage

`default_nettype wire

>>> hdl/sdf_primitive_distance_core.sv
// channel   signals                                         dir  handshake
// query     func point_* origin_* vec_* param_a param_b     in   start && !busy
// result    distance saturated                              out  done, one cycle
//
// one query accepted every cycle
// two square root pipelines, one result bit per stage
// the capsule clamp divider runs one quotient bit per stage beside the first root
// busy is always low; arst_n clears the valid bits only
// the receiver cannot stall, each word shows on the outputs for one cycle
`default_nettype none

module sdf_primitive_distance_core import sdf_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [2:0]                   func,
	input  wire logic signed [DATA_WIDTH-1:0] point_x,
	input  wire logic signed [DATA_WIDTH-1:0] point_y,
	input  wire logic signed [DATA_WIDTH-1:0] point_z,
	input  wire logic signed [DATA_WIDTH-1:0] origin_x,
	input  wire logic signed [DATA_WIDTH-1:0] origin_y,
	input  wire logic signed [DATA_WIDTH-1:0] origin_z,
	input  wire logic signed [DATA_WIDTH-1:0] vec_x,
	input  wire logic signed [DATA_WIDTH-1:0] vec_y,
	input  wire logic signed [DATA_WIDTH-1:0] vec_z,
	input  wire logic [DATA_WIDTH-2:0]        param_a,
	input  wire logic [DATA_WIDTH-2:0]        param_b,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      distance,
	output logic                              saturated
);

	localparam int W   = DATA_WIDTH;
	localparam int LW  = W + 1;
	localparam int OW  = W + 2;
	localparam int PW  = 2 * OW;
	localparam int SW  = 2 * W;
	localparam int NS  = PW / 2;
	localparam int MW  = W + FRAC_BITS;
	localparam int LAT = 2 * NS + 8;

	typedef struct packed {
		logic [2:0]           func;
		logic signed [LW-1:0] lx;
		logic signed [LW-1:0] ly;
		logic signed [LW-1:0] lz;
		logic signed [W-1:0]  vx;
		logic signed [W-1:0]  vy;
		logic signed [W-1:0]  vz;
		logic [W-2:0]         pa;
		logic [W-2:0]         pb;
		logic signed [OW-1:0] qmax;
		logic signed [PW-1:0] t;
		logic [SW-1:0]        s;
		logic [NS-1:0]        root1;
	} item_t;

	typedef struct packed {
		logic [PW-1:0] rad;
		logic [NS+2:0] rem;
		logic [NS-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [SW-1:0]        r;
		logic [FRAC_BITS-1:0] q;
		logic                 zero;
		logic                 one;
	} dv_t;

	function automatic sq_t sq_step(sq_t a);
		sq_t           b;
		logic [NS+2:0] r2;
		logic [NS+2:0] tr;
		r2 = {a.rem[NS:0], a.rad[PW-1 -: 2]};
		tr = {1'b0, a.root, 2'b01};
		b.rad = a.rad << 2;
		if (r2 >= tr) begin
			b.rem  = r2 - tr;
			b.root = {a.root[NS-2:0], 1'b1};
		end else begin
			b.rem  = r2;
			b.root = {a.root[NS-2:0], 1'b0};
		end
		return b;
	endfunction

	function automatic dv_t dv_step(dv_t a, logic [SW-1:0] s);
		dv_t         b;
		logic [SW:0] r2;
		logic [SW:0] dif;
		r2  = {a.r, 1'b0};
		dif = r2 - {1'b0, s};
		b   = a;
		if (r2 >= {1'b0, s}) begin
			b.r = dif[SW-1:0];
			b.q = {a.q[FRAC_BITS-2:0], 1'b1};
		end else begin
			b.r = r2[SW-1:0];
			b.q = {a.q[FRAC_BITS-2:0], 1'b0};
		end
		return b;
	endfunction

	function automatic logic [LW-1:0] absl(logic signed [LW-1:0] v);
		return v[LW-1] ? LW'(-v) : LW'(v);
	endfunction

	function automatic logic [W-1:0] magw(logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	assign busy = 1'b0;

	// stage 1: offsets from the origin
	item_t it_in;
	item_t it_s1;
	logic  v_s1;

	always_comb begin
		it_in      = '0;
		it_in.func = func;
		it_in.lx   = LW'(point_x) - LW'(origin_x);
		it_in.ly   = LW'(point_y) - LW'(origin_y);
		it_in.lz   = LW'(point_z) - LW'(origin_z);
		it_in.vx   = vec_x;
		it_in.vy   = vec_y;
		it_in.vz   = vec_z;
		it_in.pa   = param_a;
		it_in.pb   = param_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		it_s1 <= it_in;
	end

	// stage 2: products
	logic signed [OW-1:0] q_c [3];
	logic signed [OW-1:0] qp_c [3];
	logic signed [OW-1:0] l_c [3];
	logic signed [OW-1:0] vv_c [3];
	logic signed [OW-1:0] a_op [3];
	logic signed [OW-1:0] b_op [3];
	logic signed [OW-1:0] qm_c;
	item_t                it2_c;
	logic signed [PW-1:0] p_s2 [6];
	item_t                it_s2;
	logic                 v_s2;

	always_comb begin
		l_c[0]  = OW'(it_s1.lx);
		l_c[1]  = OW'(it_s1.ly);
		l_c[2]  = OW'(it_s1.lz);
		vv_c[0] = OW'(it_s1.vx);
		vv_c[1] = OW'(it_s1.vy);
		vv_c[2] = OW'(it_s1.vz);
		q_c[0]  = $signed({1'b0, absl(it_s1.lx)}) - vv_c[0];
		q_c[1]  = $signed({1'b0, absl(it_s1.ly)}) - vv_c[1];
		q_c[2]  = $signed({1'b0, absl(it_s1.lz)}) - vv_c[2];
		for (int i = 0; i < 3; i++) begin
			qp_c[i] = q_c[i][OW-1] ? '0 : q_c[i];
		end
		qm_c = q_c[0];
		if (q_c[1] > qm_c) begin
			qm_c = q_c[1];
		end
		if (q_c[2] > qm_c) begin
			qm_c = q_c[2];
		end
		unique case (it_s1.func)
			FN_SPHERE: begin
				a_op = l_c;
				b_op = l_c;
			end
			FN_BOX: begin
				a_op = qp_c;
				b_op = qp_c;
			end
			FN_TORUS, FN_CYLINDER: begin
				a_op    = l_c;
				b_op    = l_c;
				a_op[1] = '0;
				b_op[1] = '0;
			end
			FN_CAPSULE, FN_PLANE: begin
				a_op = l_c;
				b_op = vv_c;
			end
			default: begin
				a_op = '{default: '0};
				b_op = '{default: '0};
			end
		endcase
		it2_c      = it_s1;
		it2_c.qmax = qm_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s2[i]     <= PW'(a_op[i]) * PW'(b_op[i]);
			p_s2[i + 3] <= PW'(vv_c[i]) * PW'(vv_c[i]);
		end
		it_s2 <= it2_c;
	end

	// stage 3: sums
	logic signed [PW-1:0] s_sum_c;
	item_t                it3_c;
	item_t                it_s3;
	logic                 v_s3;

	assign s_sum_c = p_s2[3] + p_s2[4] + p_s2[5];

	always_comb begin
		it3_c   = it_s2;
		it3_c.t = p_s2[0] + p_s2[1] + p_s2[2];
		it3_c.s = s_sum_c[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		it_s3 <= it3_c;
	end

	// first root, with the capsule divider alongside
	sq_t   sq_sa_in [NS];
	sq_t   sq_sa [NS];
	dv_t   dv_sa_in [NS];
	dv_t   dv_sa [NS];
	item_t it_sa_in [NS];
	item_t it_sa [NS];
	logic  v_sa_in [NS];
	logic  v_sa [NS];
	logic  tpos_c;
	logic  dzero_c;
	logic  hone_c;

	assign tpos_c  = !it_s3.t[PW-1] && (it_s3.t != '0);
	assign dzero_c = (it_s3.s == '0) || !tpos_c;
	assign hone_c  = !dzero_c && (it_s3.t >= $signed(PW'(it_s3.s)));

	for (genvar k = 0; k < NS; k++) begin : g_sqa
		if (k > 0) begin : g_link
			assign sq_sa_in[k] = sq_sa[k-1];
			assign dv_sa_in[k] = dv_sa[k-1];
			assign it_sa_in[k] = it_sa[k-1];
			assign v_sa_in[k]  = v_sa[k-1];
		end else begin : g_head
			assign sq_sa_in[k] = '{rad: it_s3.t, rem: '0, root: '0};
			assign dv_sa_in[k] = '{r: it_s3.t[SW-1:0], q: '0, zero: dzero_c, one: hone_c};
			assign it_sa_in[k] = it_s3;
			assign v_sa_in[k]  = v_s3;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sa[k] <= 1'b0;
			end else begin
				v_sa[k] <= v_sa_in[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_sa[k] <= sq_step(sq_sa_in[k]);
			it_sa[k] <= it_sa_in[k];
		end

		if (k < FRAC_BITS) begin : g_div
			always_ff @(posedge clk) begin
				dv_sa[k] <= dv_step(dv_sa_in[k], it_sa_in[k].s);
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				dv_sa[k] <= dv_sa_in[k];
			end
		end
	end

	// stage 4: torus ring offset, capsule scaling products
	logic [FRAC_BITS-1:0] hm_c;
	item_t                it4_c;
	logic signed [OW-1:0] tt_s4;
	logic [MW-1:0]        sm_s4 [3];
	logic                 hone_s4;
	item_t                it_s4;
	logic                 v_s4;

	assign hm_c = dv_sa[NS-1].zero ? '0 : dv_sa[NS-1].q;

	always_comb begin
		it4_c       = it_sa[NS-1];
		it4_c.root1 = sq_sa[NS-1].root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_sa[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		it_s4       <= it4_c;
		tt_s4       <= $signed(sq_sa[NS-1].root) - $signed(OW'(it_sa[NS-1].pa));
		sm_s4[0]    <= MW'(magw(it_sa[NS-1].vx)) * MW'(hm_c);
		sm_s4[1]    <= MW'(magw(it_sa[NS-1].vy)) * MW'(hm_c);
		sm_s4[2]    <= MW'(magw(it_sa[NS-1].vz)) * MW'(hm_c);
		hone_s4     <= dv_sa[NS-1].one;
	end

	// stage 5: second-pass operands
	logic signed [OW-1:0] sv_c [3];
	logic signed [OW-1:0] v4_c [3];
	logic signed [OW-1:0] l4_c [3];
	logic signed [OW-1:0] o_c [3];
	logic signed [OW-1:0] op_s5 [3];
	item_t                it_s5;
	logic                 v_s5;

	always_comb begin
		v4_c[0] = OW'(it_s4.vx);
		v4_c[1] = OW'(it_s4.vy);
		v4_c[2] = OW'(it_s4.vz);
		l4_c[0] = OW'(it_s4.lx);
		l4_c[1] = OW'(it_s4.ly);
		l4_c[2] = OW'(it_s4.lz);
		for (int i = 0; i < 3; i++) begin
			if (hone_s4) begin
				sv_c[i] = v4_c[i];
			end else if (v4_c[i][OW-1]) begin
				sv_c[i] = -$signed(OW'(sm_s4[i][MW-1:FRAC_BITS]));
			end else begin
				sv_c[i] = $signed(OW'(sm_s4[i][MW-1:FRAC_BITS]));
			end
		end
		unique case (it_s4.func)
			FN_TORUS: begin
				o_c[0] = tt_s4;
				o_c[1] = l4_c[1];
				o_c[2] = '0;
			end
			FN_CAPSULE: begin
				for (int i = 0; i < 3; i++) begin
					o_c[i] = l4_c[i] - sv_c[i];
				end
			end
			default: begin
				o_c = '{default: '0};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s5 <= o_c;
		it_s5 <= it_s4;
	end

	// stage 6: squares
	logic signed [PW-1:0] sq_s6 [3];
	item_t                it_s6;
	logic                 v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= PW'(op_s5[i]) * PW'(op_s5[i]);
		end
		it_s6 <= it_s5;
	end

	// stage 7: sum
	logic [PW-1:0] rad_s7;
	item_t         it_s7;
	logic          v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		rad_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
		it_s7  <= it_s6;
	end

	// second root
	sq_t   sq_sb_in [NS];
	sq_t   sq_sb [NS];
	item_t it_sb_in [NS];
	item_t it_sb [NS];
	logic  v_sb_in [NS];
	logic  v_sb [NS];

	for (genvar k = 0; k < NS; k++) begin : g_sqb
		if (k > 0) begin : g_link
			assign sq_sb_in[k] = sq_sb[k-1];
			assign it_sb_in[k] = it_sb[k-1];
			assign v_sb_in[k]  = v_sb[k-1];
		end else begin : g_head
			assign sq_sb_in[k] = '{rad: rad_s7, rem: '0, root: '0};
			assign it_sb_in[k] = it_s7;
			assign v_sb_in[k]  = v_s7;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sb[k] <= 1'b0;
			end else begin
				v_sb[k] <= v_sb_in[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_sb[k] <= sq_step(sq_sb_in[k]);
			it_sb[k] <= it_sb_in[k];
		end
	end

	// stage 8: per-kind result and clipping
	item_t                itf;
	logic signed [PW-1:0] r1_c;
	logic signed [PW-1:0] r2_c;
	logic signed [PW-1:0] pa_c;
	logic signed [PW-1:0] pb_c;
	logic signed [PW-1:0] e1_c;
	logic signed [PW-1:0] e2_c;
	logic signed [PW-1:0] d_c;
	logic                 sat_c;
	logic signed [W-1:0]  dist_c;
	logic                 v_s8;
	logic signed [W-1:0]  dist_s8;
	logic                 sat_s8;

	always_comb begin
		itf  = it_sb[NS-1];
		r1_c = $signed(PW'(itf.root1));
		r2_c = $signed(PW'(sq_sb[NS-1].root));
		pa_c = $signed(PW'(itf.pa));
		pb_c = $signed(PW'(itf.pb));
		e1_c = r1_c - pa_c;
		e2_c = $signed(PW'(absl(itf.ly))) - $signed(PW'(itf.pb[W-2:1]));
		unique case (itf.func)
			FN_SPHERE:   d_c = r1_c - pa_c;
			FN_BOX:      d_c = r1_c + (itf.qmax[OW-1] ? PW'(itf.qmax) : '0);
			FN_TORUS:    d_c = r2_c - pb_c;
			FN_CAPSULE:  d_c = r2_c - pa_c;
			FN_CYLINDER: d_c = (e1_c > e2_c) ? e1_c : e2_c;
			FN_PLANE:    d_c = itf.t >>> FRAC_BITS;
			default:     d_c = '0;
		endcase
		sat_c = !((&d_c[PW-1:W-1]) || !(|d_c[PW-1:W-1]));
		if (!sat_c) begin
			dist_c = d_c[W-1:0];
		end else if (d_c[PW-1]) begin
			dist_c = {1'b1, {(W-1){1'b0}}};
		end else begin
			dist_c = {1'b0, {(W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_sb[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		dist_s8 <= dist_c;
		sat_s8  <= sat_c;
	end

	assign done      = v_s8;
	assign distance  = dist_s8;
	assign saturated = sat_s8;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result word missing after fixed latency");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
		(distance == {1'b1, {(W-1){1'b0}}} || distance == {1'b0, {(W-1){1'b1}}}))
		else $error("saturated word is not a range limit");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func[2] && func[1]) |-> ##LAT (distance == '0 && !saturated))
		else $error("unknown kind gave nonzero word");

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
	import sdf_pkg::*;

	typedef struct {
		logic [2:0]         f;
		logic signed [31:0] px, py, pz, ox, oy, oz, vx, vy, vz;
		logic [30:0]        a, b;
	} query_t;

	typedef struct {
		logic signed [31:0] d;
		logic               s;
	} dist_t;

	class dist_board;
		dist_t pending[$];
		int    errs = 0;

		function void note(dist_t e);
			pending = {pending, e};
		endfunction

		function void check(dist_t got);
			dist_t e;
			if (pending.size() == 0) begin
				errs++;
				$error("distance word with none pending: %0d", got.d);
				return;
			end
			e = pending.pop_front();
			if (got.d !== e.d) begin
				errs++;
				$error("distance expected %0d actual %0d", e.d, got.d);
			end
			if (got.s !== e.s) begin
				errs++;
				$error("saturated expected %0d actual %0d", e.s, got.s);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [2:0] func = 0;
	logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
	logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic signed [31:0] vec_x = 0, vec_y = 0, vec_z = 0;
	logic [30:0] param_a = 0, param_b = 0;
	logic busy, done, saturated;
	logic signed [31:0] distance;

	dist_board sb = new;
	int idle_pct = 0;

	sdf_primitive_distance_core #(.DATA_WIDTH(32)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.param_a(param_a), .param_b(param_b),
		.done(done), .distance(distance), .saturated(saturated)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic signed [127:0] wide(longint v);
		logic signed [127:0] w;
		w = v;
		return w;
	endfunction

	function automatic logic signed [127:0] wsq(longint v);
		return wide(v) * wide(v);
	endfunction

	function automatic longint root(logic [127:0] n);
		logic [127:0] r, bt, t;
		r = 0;
		bt = 128'h1 << 126;
		while (bt != 0) begin
			t = r + bt;
			if (n >= t) begin
				n = n - t;
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint len3(longint x, longint y, longint z);
		return root(wsq(x) + wsq(y) + wsq(z));
	endfunction

	function automatic longint len2(longint x, longint y);
		return root(wsq(x) + wsq(y));
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint maxl(longint x, longint y);
		return x > y ? x : y;
	endfunction

	function automatic longint scale_seg(longint v, longint h);
		longint m;
		if (h >= 65536) return v;
		m = (absl(v) * h) >>> 16;
		return v < 0 ? -m : m;
	endfunction

	function automatic dist_t predict_distance(query_t q);
		longint lx, ly, lz, vx, vy, vz, pa, pb, qx, qy, qz, h;
		logic signed [127:0] d, t, s, r;
		dist_t res;
		lx = longint'(q.px) - longint'(q.ox);
		ly = longint'(q.py) - longint'(q.oy);
		lz = longint'(q.pz) - longint'(q.oz);
		vx = q.vx; vy = q.vy; vz = q.vz;
		pa = longint'(q.a); pb = longint'(q.b);
		d = 0;
		case (q.f)
			FN_SPHERE: d = len3(lx, ly, lz) - pa;
			FN_BOX: begin
				qx = absl(lx) - vx; qy = absl(ly) - vy; qz = absl(lz) - vz;
				d = len3(maxl(qx, 0), maxl(qy, 0), maxl(qz, 0))
					+ ((maxl(qx, maxl(qy, qz)) < 0) ? maxl(qx, maxl(qy, qz)) : 0);
			end
			FN_TORUS: d = len2(len2(lx, lz) - pa, ly) - pb;
			FN_CAPSULE: begin
				t = wide(lx) * wide(vx) + wide(ly) * wide(vy) + wide(lz) * wide(vz);
				s = wsq(vx) + wsq(vy) + wsq(vz);
				h = 0;
				if (s == 0 || t <= 0) begin
					h = 0;
				end else if (t >= s) begin
					h = 65536;
				end else begin
					r = t;
					for (int i = 0; i < 16; i++) begin
						r = r <<< 1;
						h = h << 1;
						if (r >= s) begin
							r = r - s;
							h = h | 1;
						end
					end
				end
				d = len3(lx - scale_seg(vx, h), ly - scale_seg(vy, h),
					lz - scale_seg(vz, h)) - pa;
			end
			FN_CYLINDER: d = maxl(len2(lx, lz) - pa, absl(ly) - (pb >>> 1));
			FN_PLANE: begin
				t = wide(lx) * wide(vx) + wide(ly) * wide(vy) + wide(lz) * wide(vz);
				d = t >>> 16;
			end
			default: d = 0;
		endcase
		res.s = 1'b1;
		if (d > 128'sh7fffffff) res.d = 32'sh7fffffff;
		else if (d < -128'sh80000000) res.d = 32'sh80000000;
		else begin
			res.d = d[31:0];
			res.s = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		query_t cur;
		if (arst_n && start && !busy) begin
			cur = '{func, point_x, point_y, point_z, origin_x, origin_y, origin_z,
				vec_x, vec_y, vec_z, param_a, param_b};
			sb.note(predict_distance(cur));
		end
		if (arst_n && done)
			sb.check('{distance, saturated});
	end

	// holds start high at the accepting edge; the next call decides whether to drop it
	task automatic send_query(query_t q);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= q.f;
		point_x <= q.px; point_y <= q.py; point_z <= q.pz;
		origin_x <= q.ox; origin_y <= q.oy; origin_z <= q.oz;
		vec_x <= q.vx; vec_y <= q.vy; vec_z <= q.vz;
		param_a <= q.a; param_b <= q.b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			2: case ($urandom_range(0, 4))
				0: return 32'sh0;
				1: return 32'sh7fffffff;
				2: return 32'sh80000000;
				3: return -32'sh1;
				default: return 32'sh10000;
			endcase
			default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	function automatic logic [30:0] rand_param();
		case ($urandom_range(0, 3))
			0: return 31'($urandom);
			1: return $urandom_range(0, 31'h7fffffff) == 0 ? 31'h7fffffff : 31'h0;
			default: return 31'($urandom_range(0, 32'h0100_0000));
		endcase
	endfunction

	function automatic query_t rand_query();
		query_t q;
		q.f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		q.px = rand_coord(); q.py = rand_coord(); q.pz = rand_coord();
		q.ox = rand_coord(); q.oy = rand_coord(); q.oz = rand_coord();
		q.vx = rand_coord(); q.vy = rand_coord(); q.vz = rand_coord();
		q.a = rand_param(); q.b = rand_param();
		if (q.f == FN_CAPSULE && $urandom_range(0, 9) == 0) begin
			q.vx = 0; q.vy = 0; q.vz = 0;
		end
		return q;
	endfunction

	initial begin
		query_t q;
		int pcts[4] = '{0, 57, 31, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each kind at both extremes, empty capsule, partial capsule, inverted box, saturating plane, unknown kinds
		for (int k = 0; k < 8; k++) begin
			q = '{3'(k), 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
				32'sh80000000, 32'sh80000000, 32'sh80000000,
				32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff};
			send_query(q);
			q = '{3'(k), 32'sh80000000, 32'sh0, 32'sh7fffffff,
				32'sh7fffffff, 32'sh0, 32'sh80000000,
				32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h0, 31'h0};
			send_query(q);
		end
		q = '{FN_CAPSULE, 32'sh30000, 32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			32'sh0, 32'sh0, 32'sh0, 31'h8000, 31'h0};
		send_query(q);
		q = '{FN_CAPSULE, 32'sh18000, 32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			32'sh40000, 32'sh0, 32'sh0, 31'h8000, 31'h0};
		send_query(q);
		q = '{FN_BOX, 32'sh10000, 32'sh20000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			-32'sh10000, 32'sh30000, -32'sh20000, 31'h0, 31'h0};
		send_query(q);
		q = '{FN_PLANE, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh80000000, 32'sh0, 32'sh0,
			32'sh10000, 32'sh0, 32'sh0, 31'h0, 31'h0};
		send_query(q);

		for (int p = 0; p < 4; p++) begin
			idle_pct = pcts[p];
			for (int i = 0; i < 400; i++) send_query(rand_query());
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errs == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

>>> sdf_primitive_distance_core.f
hdl/sdf_pkg.sv
hdl/sdf_primitive_distance_core.sv
verif/tb.sv
